FILE: design/mavg_pkg.sv
// mavg_pkg: shared types and fixed constants of the moving average filter
// no dependencies; imported by moving_average_filter, mavg_checker and the bench
`timescale 1ns / 1ps
`default_nettype none

package mavg_pkg;

   localparam int DATA_W       = 16;  // sample and average width
   localparam int WIN_W        = 7;   // window size register width
   localparam int RESET_WINDOW = 16;  // window size after reset

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_FILL   = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPD,
      ST_DIV,
      ST_FILL,
      ST_SUM,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

FILE: design/mavg_ram.sv
// mavg_ram: generic single write port, single read port ram, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mavg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: design/mavg_div.sv
// mavg_div: restoring divider, one quotient bit per cycle
// depends on nothing but its parameters; used by the filter top level
`timescale 1ns / 1ps
`default_nettype none

module mavg_div #(
   parameter int NUM_W = 22,
   parameter int DEN_W = 7
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output      logic             done,
   output      logic [NUM_W-1:0] quotient
);

   localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W:0]    shifted;
   logic [DEN_W:0]    diff;
   logic              fits;
   logic              last;

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};
   assign last    = step_ff == STEP_W'(NUM_W - 1);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         den_in  = denom;
         quo_in  = numer;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         if (NUM_W > 1) begin
            quo_in = {quo_ff[NUM_W-2:0], fits};
         end else begin
            quo_in = NUM_W'(fits);
         end
         step_in = step_ff + STEP_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: design/moving_average_filter.sv
// moving_average_filter: boxcar moving average over a ring of samples in ram
// depends on mavg_pkg, mavg_ram and mavg_div
`timescale 1ns / 1ps
`default_nettype none

//  channel | ports                          | direction | transfer when
//  --------+--------------------------------+-----------+----------------------
//  req     | req_command, req_sample_value  | in        | req_valid & req_ready
//  rsp     | rsp_average                    | out       | rsp_valid & rsp_ready
//  csr     | csr_wdata (window size)        | in        | csr_we
//
//  sample command: ram read at the transfer edge, sum update and write back in
//    ST_UPD, then the serial divider in ST_DIV, then ST_DONE loads the output
//    register and raises rsp_valid once the rsp slot is free
//  fill command: one ram write per entry below the window; read goes to ST_DONE
//  req_ready returns as the result is loaded, unless csr_we is high
//  a csr write starts a resum pass, req_ready low until it ends
//  reset clears per-entry valid bits at once, so there is no clearing pass
//  a new request is taken while the previous result still waits on rsp

module moving_average_filter #(
   parameter int MAX_WINDOW = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [1:0]                    req_command,
   input  wire logic [mavg_pkg::DATA_W-1:0]   req_sample_value,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [mavg_pkg::DATA_W-1:0]   rsp_average,
   input  wire logic                          csr_we,
   input  wire logic [mavg_pkg::WIN_W-1:0]    csr_wdata
);

   import mavg_pkg::*;

   // ring index width and running sum width follow the store depth
   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SUM_W = DATA_W + $clog2(MAX_WINDOW);
   localparam int PTR_W = (IDX_W > WIN_W) ? IDX_W + 1 : WIN_W + 1;
   localparam int PROD_W = DATA_W + WIN_W;
   // largest window the 7-bit register can select with this depth
   localparam logic [WIN_W-1:0] WIN_CAP =
      WIN_W'((MAX_WINDOW > (2 ** WIN_W - 1)) ? (2 ** WIN_W - 1) : MAX_WINDOW);
   localparam logic [WIN_W-1:0] WIN_RST =
      WIN_W'((RESET_WINDOW > MAX_WINDOW) ? MAX_WINDOW : RESET_WINDOW);

   // control state
   state_type              state_ff, state_in;
   logic [WIN_W-1:0]       window_ff, window_in;
   logic [IDX_W-1:0]       wp_ff, wp_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [DATA_W-1:0]      avg_ff, avg_in;
   logic [WIN_W-1:0]       cnt_ff, cnt_in;
   logic                   pend_ff, pend_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [MAX_WINDOW-1:0]  vld_ff, vld_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   // payload
   logic [DATA_W-1:0]      val_ff, val_in;
   logic [DATA_W-1:0]      rsp_avg_ff, rsp_avg_in;

   // ram ports
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [DATA_W-1:0]      rd_data;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [DATA_W-1:0]      wr_data;

   // divider
   logic                   div_start;
   logic                   div_done;
   logic [SUM_W-1:0]       div_quo;

   logic                   req_fire;
   logic                   slot_free;
   logic [DATA_W-1:0]      mem_q;
   logic [WIN_W-1:0]       win_clamped;
   logic [PROD_W-1:0]      fill_prod;
   logic [PTR_W-1:0]       wp_inc;
   logic [IDX_W-1:0]       wp_next;
   logic                   fill_last;
   logic                   sweep_more;

   assign req_ready = (state_ff == ST_IDLE) && !csr_we;
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // entries never written since reset read as zero
   assign mem_q = rd_vld_ff ? rd_data : '0;

   // zero selects one sample, anything beyond the store saturates
   always_comb begin
      win_clamped = csr_wdata;
      if (csr_wdata == '0) begin
         win_clamped = WIN_W'(1);
      end else if (csr_wdata > WIN_CAP) begin
         win_clamped = WIN_CAP;
      end
   end

   assign fill_prod = PROD_W'(req_sample_value) * PROD_W'(window_ff);

   // pointer wraps at the window size
   assign wp_inc  = PTR_W'(wp_ff) + PTR_W'(1);
   assign wp_next = (wp_inc >= PTR_W'(window_ff)) ? '0 : IDX_W'(wp_inc);

   assign fill_last  = cnt_ff == (window_ff - WIN_W'(1));
   assign sweep_more = cnt_ff < window_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (cmd_type'(req_command))
                  CMD_SAMPLE: state_in = ST_UPD;
                  CMD_FILL:   state_in = ST_FILL;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_UPD:  state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_FILL: begin
            if (fill_last) begin
               state_in = ST_DONE;
            end
         end
         ST_SUM: begin
            if (!sweep_more && !pend_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // a window write always restarts the resum pass
      if (csr_we) begin
         state_in = ST_SUM;
      end
   end

   // datapath and ram control
   always_comb begin
      window_in    = window_ff;
      wp_in        = wp_ff;
      sum_in       = sum_ff;
      avg_in       = avg_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      vld_in       = vld_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_avg_in   = rsp_avg_ff;
      rd_en        = 1'b0;
      rd_addr      = wp_ff;
      wr_en        = 1'b0;
      wr_addr      = wp_ff;
      wr_data      = val_ff;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               val_in = req_sample_value;
               cnt_in = '0;
               unique case (cmd_type'(req_command))
                  CMD_SAMPLE: begin
                     // fetch the oldest sample, replaced next cycle
                     rd_en   = 1'b1;
                     rd_addr = wp_ff;
                  end
                  CMD_FILL: begin
                     sum_in = SUM_W'(fill_prod);
                     avg_in = req_sample_value;
                  end
                  default: ;
               endcase
            end
         end
         ST_UPD: begin
            sum_in    = sum_ff - SUM_W'(mem_q) + SUM_W'(val_ff);
            wr_en     = 1'b1;
            wr_addr   = wp_ff;
            wr_data   = val_ff;
            wp_in     = wp_next;
            div_start = 1'b1;
         end
         ST_DIV: begin
            if (div_done) begin
               avg_in = div_quo[DATA_W-1:0];
            end
         end
         ST_FILL: begin
            // one entry per cycle, below the window only
            wr_en   = 1'b1;
            wr_addr = IDX_W'(cnt_ff);
            wr_data = val_ff;
            cnt_in  = cnt_ff + WIN_W'(1);
         end
         ST_SUM: begin
            // read one entry per cycle, add it as the data comes back
            if (sweep_more) begin
               rd_en   = 1'b1;
               rd_addr = IDX_W'(cnt_ff);
               cnt_in  = cnt_ff + WIN_W'(1);
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               sum_in = sum_ff + SUM_W'(mem_q);
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = avg_ff;
            end
         end
         default: ;
      endcase

      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end

      if (csr_we) begin
         window_in = win_clamped;
         wp_in     = '0;
         sum_in    = '0;
         cnt_in    = '0;
         pend_in   = 1'b0;
      end
   end

   // valid bit travels with the registered ram read
   assign rd_vld_in = rd_en ? vld_ff[rd_addr] : rd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WIN_RST;
         wp_ff        <= '0;
         sum_ff       <= '0;
         avg_ff       <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rd_vld_ff    <= 1'b0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         wp_ff        <= wp_in;
         sum_ff       <= sum_in;
         avg_ff       <= avg_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rd_vld_ff    <= rd_vld_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff     <= val_in;
      rsp_avg_ff <= rsp_avg_in;
   end

   mavg_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mavg_div #(
      .NUM_W (SUM_W),
      .DEN_W (WIN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (sum_in),
      .denom    (window_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_avg_ff;

endmodule

`default_nettype wire

FILE: design/mavg_checker.sv
// mavg_checker: port-level assertions for the moving average filter
// depends on mavg_pkg; bound to moving_average_filter below
`timescale 1ns / 1ps
`default_nettype none

module mavg_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic [1:0]                    req_command,
   input wire logic [mavg_pkg::DATA_W-1:0]   req_sample_value,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [mavg_pkg::DATA_W-1:0]   rsp_average,
   input wire logic                          csr_we,
   input wire logic [mavg_pkg::WIN_W-1:0]    csr_wdata
);

   import mavg_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average))
      else $error("rsp changed while stalled");

   // one request in flight at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a window write starts the resum pass, which blocks requests
   a_resum_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("request port open during resum");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind moving_average_filter mavg_checker u_mavg_checker (.*);

`default_nettype wire

FILE: tb/moving_average_filter_test.sv
// moving_average_filter_test: self-checking bench for the boxcar moving average filter
// drives sample, fill and read requests plus window size writes, predicts every average
// depends on mavg_pkg and moving_average_filter
`timescale 1ns / 1ps

module moving_average_filter_test;
   import mavg_pkg::*;

   localparam int MAX_WINDOW   = 64;
   localparam int SUM_W        = 22;    // running sum width at the default depth
   localparam int LONG_HOLD    = 300;   // receiver hold-off that backs up the pipeline
   localparam int RANDOM_ITEMS = 1800;
   localparam int DRAIN_CYCLES = 40;    // settling wait after the bench has drained
   localparam int MAX_REPORTS  = 20;

   // the fourth command code is unused and behaves as a read
   localparam logic [1:0] CMD_SPARE = 2'd3;

   typedef struct packed {
      logic [1:0]        command;
      logic [DATA_W-1:0] value;
   } req_item_type;

   // ---------------------------------------------------------------------------------
   // clock, reset and block inputs, all known from time zero
   // ---------------------------------------------------------------------------------
   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic [1:0]        req_command      = CMD_READ;
   logic [DATA_W-1:0] req_sample_value = '0;
   logic              rsp_ready        = 1'b0;
   logic              csr_we           = 1'b0;
   logic [WIN_W-1:0]  csr_wdata        = '0;
   logic              req_ready;
   logic              rsp_valid;
   logic [DATA_W-1:0] rsp_average;

   always #4 clock = ~clock;

   moving_average_filter #(
      .MAX_WINDOW(MAX_WINDOW)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_average      (rsp_average),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   // ---------------------------------------------------------------------------------
   // shadow copy of the filter state, updated as each request transfer happens
   // ---------------------------------------------------------------------------------
   logic [DATA_W-1:0] win_samples [MAX_WINDOW];
   logic [SUM_W-1:0]  win_sum;
   int                win_ptr;
   int                win_size;
   logic [DATA_W-1:0] last_avg;

   // window write: clamp, rewind the pointer and resum the kept entries;
   // the last average is left alone
   function automatic void set_window(logic [WIN_W-1:0] raw);
      if (raw == 0)
         win_size = 1;
      else if (raw > MAX_WINDOW)
         win_size = MAX_WINDOW;
      else
         win_size = int'(raw);
      win_ptr = 0;
      win_sum = '0;
      for (int i = 0; i < win_size; i++)
         win_sum += win_samples[i];
   endfunction

   // applies one request to the shadow state and returns the average it produces
   function automatic logic [DATA_W-1:0] next_average(logic [1:0] cmd,
                                                      logic [DATA_W-1:0] value);
      if (win_ptr >= win_size)
         win_ptr = 0;
      if (cmd == CMD_SAMPLE) begin
         // oldest entry drops out of the sum, new one goes in
         win_sum = win_sum - win_samples[win_ptr] + value;
         win_samples[win_ptr] = value;
         win_ptr = (win_ptr + 1 >= win_size) ? 0 : win_ptr + 1;
         last_avg = DATA_W'(win_sum / win_size);
      end else if (cmd == CMD_FILL) begin
         // fill only touches entries below the window, pointer stays put
         for (int i = 0; i < win_size; i++)
            win_samples[i] = value;
         win_sum = SUM_W'(value * win_size);
         last_avg = value;
      end
      // read and the spare code just return the last average
      return last_avg;
   endfunction

   // ---------------------------------------------------------------------------------
   // bookkeeping shared by stimulus, driver and monitor
   // ---------------------------------------------------------------------------------
   req_item_type      pending_reqs[$];        // filled by stimulus, drained by the driver
   logic [DATA_W-1:0] expected_averages[$];   // one per accepted request, oldest first
   bit                gaps_on       = 1'b0;   // random idling on both sides for this phase
   int                hold_requests = 0;      // bumped by stimulus to ask for a long hold
   int                holds_served  = 0;
   int                errors        = 0;
   int                reqs_accepted = 0;
   int                samples_sent  = 0;
   int                fills_sent    = 0;
   int                reads_sent    = 0;
   int                averages_checked = 0;
   int                window_writes = 0;

   task automatic report_mismatch(string msg);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!gaps_on || roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ---------------------------------------------------------------------------------
   // request driver: one item in flight on the port, payload held until transfer
   // ---------------------------------------------------------------------------------
   int           send_gap = 0;
   bit           req_taken;
   req_item_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            expected_averages.push_back(next_average(req_command, req_sample_value));
            reqs_accepted++;
            case (req_command)
               CMD_SAMPLE: samples_sent++;
               CMD_FILL:   fills_sent++;
               default:    reads_sent++;
            endcase
            send_gap = pick_gap();
         end
         if (req_valid && !req_taken) begin
            // still waiting on ready, keep valid and payload as they are
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            next_item = pending_reqs.pop_front();
            req_valid        <= 1'b1;
            req_command      <= next_item.command;
            req_sample_value <= next_item.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // result monitor: checks each transfer, and runs the ready stalls in its own count
   // ---------------------------------------------------------------------------------
   int                stall_left = 0;
   logic [DATA_W-1:0] want_avg;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_averages.size() == 0) begin
               report_mismatch($sformatf("average %h with nothing expected", rsp_average));
            end else begin
               want_avg = expected_averages.pop_front();
               averages_checked++;
               if (rsp_average !== want_avg)
                  report_mismatch($sformatf("average %h, expected %h", rsp_average, want_avg));
            end
         end
         // a long hold lets the block fill up and push back on the request side
         if (hold_requests != holds_served) begin
            stall_left   = LONG_HOLD;
            holds_served = hold_requests;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (gaps_on && $urandom_range(0, 2) == 0)
               stall_left = pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------------
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
         3:       return DATA_W'($urandom_range(0, 15));
         default: return DATA_W'($urandom);
      endcase
   endfunction

   // extremes, out-of-range codes and small windows show up often, the rest spread over the range
   function automatic logic [WIN_W-1:0] pick_window();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return WIN_W'(1);
         2:       return WIN_W'(MAX_WINDOW);
         3:       return '1;
         4:       return WIN_W'($urandom_range(MAX_WINDOW + 1, 126));
         5, 6:    return WIN_W'($urandom_range(2, 5));
         default: return WIN_W'($urandom_range(1, MAX_WINDOW));
      endcase
   endfunction

   task automatic queue_req(logic [1:0] cmd, logic [DATA_W-1:0] value);
      pending_reqs.push_back('{command: cmd, value: value});
   endtask

   task automatic queue_random();
      int         roll;
      logic [1:0] cmd;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         cmd = CMD_SAMPLE;
      else if (roll < 78)
         cmd = CMD_FILL;
      else if (roll < 93)
         cmd = CMD_READ;
      else
         cmd = CMD_SPARE;
      queue_req(cmd, pick_value());
   endtask

   // sender pause: nothing queued, nothing on the port, every average back
   task automatic wait_drained();
      @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_averages.size() != 0)
         @(negedge clock);
   endtask

   // window writes only happen with the block idle
   task automatic write_window(logic [WIN_W-1:0] raw);
      wait_drained();
      @(posedge clock);
      csr_wdata <= raw;
      csr_we    <= 1'b1;
      set_window(raw);
      window_writes++;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   int queued_total;
   int phase;
   int phase_len;

   initial begin
      for (int i = 0; i < MAX_WINDOW; i++)
         win_samples[i] = '0;
      win_sum  = '0;
      win_ptr  = 0;
      win_size = RESET_WINDOW;
      last_avg = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset window of 16
      queue_req(CMD_READ,   16'h0000);    // average after reset
      queue_req(CMD_SPARE,  16'hFFFF);    // unused code reads back
      queue_req(CMD_SAMPLE, 16'hFFFF);
      queue_req(CMD_SAMPLE, 16'h0000);
      queue_req(CMD_FILL,   16'hFFFF);    // largest sum for this window
      queue_req(CMD_SAMPLE, 16'h0000);
      queue_req(CMD_READ,   16'h1234);
      queue_req(CMD_FILL,   16'h0000);    // flush
      queue_req(CMD_SAMPLE, 16'h8000);

      // zero is taken as a window of one
      write_window('0);
      queue_req(CMD_SAMPLE, 16'hFFFF);
      queue_req(CMD_SAMPLE, 16'h1234);
      queue_req(CMD_READ,   16'h0000);

      // all ones saturates to the full depth, resum over stale entries
      write_window('1);
      queue_req(CMD_SAMPLE, 16'h7FFF);
      queue_req(CMD_FILL,   16'hFFFF);    // sum reaches its widest value
      queue_req(CMD_SAMPLE, 16'hFFFF);
      queue_req(CMD_SAMPLE, 16'h0000);

      // shrink without a fill: kept entries resummed, pointer wraps
      write_window(WIN_W'(3));
      repeat (4) queue_req(CMD_SAMPLE, 16'h00FF);

      // exact maximum, then one past it
      write_window(WIN_W'(MAX_WINDOW));
      queue_req(CMD_READ,   16'h0000);
      queue_req(CMD_SAMPLE, 16'h5555);
      queue_req(CMD_SAMPLE, 16'hAAAA);
      write_window(WIN_W'(MAX_WINDOW + 1));
      queue_req(CMD_READ,   16'hFFFF);

      // random phases: new window, usually a fill as software would issue, then traffic
      queued_total = 0;
      phase = 0;
      while (queued_total < RANDOM_ITEMS) begin
         write_window(pick_window());
         gaps_on = ($urandom_range(0, 3) != 0);
         if (phase == 3) begin
            // receiver holds off while the sender keeps offering back to back
            gaps_on = 1'b0;
            hold_requests++;
            phase_len = 40;
            repeat (phase_len) queue_random();
         end else begin
            phase_len = $urandom_range(40, 120);
            if ($urandom_range(0, 4) != 0) begin
               queue_req(CMD_FILL, pick_value());
               phase_len++;
            end
            repeat (phase_len) queue_random();
         end
         queued_total += phase_len;
         phase++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_averages.size() != 0)
         report_mismatch($sformatf("%0d averages never returned", expected_averages.size()));

      $display("covered %0d requests: %0d samples, %0d fills, %0d reads, %0d window writes",
               reqs_accepted, samples_sent, fills_sent, reads_sent, window_writes);
      $display("%0d averages compared, %0d mismatches", averages_checked, errors);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
